@@ design/skt_pkg.sv @@
// skt_pkg: types and constants shared by the sorted key table modules.
// Depends on nothing.
package skt_pkg;

    // table size in entries
    localparam int CAPACITY = 64;

    // command codes
    localparam logic [2:0] FUNC_CLEAR   = 3'd0;
    localparam logic [2:0] FUNC_INS_POS = 3'd1;
    localparam logic [2:0] FUNC_INS_SRT = 3'd2;
    localparam logic [2:0] FUNC_BSEARCH = 3'd3;
    localparam logic [2:0] FUNC_LSEARCH = 3'd4;
    localparam logic [2:0] FUNC_DELETE  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BS_READ,
        ST_BS_CMP,
        ST_LS_READ,
        ST_LS_CMP,
        ST_SH_READ,
        ST_SH_WRITE,
        ST_DONE
    } skt_state_t;

    // datapath operation selects
    typedef enum logic [1:0] {
        SH_NONE,
        SH_UP,
        SH_DOWN
    } skt_shift_t;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture command fields
        logic       bs_init;    // lo=0, hi=count-1
        logic       bs_read;    // issue read at mid
        logic       bs_step;    // compare and narrow
        logic       ls_init;
        logic       ls_read;
        logic       ls_step;
        logic       sh_init;    // start shift walk
        logic       sh_read;
        logic       sh_write;   // write shifted word, step pointer
        logic       ins_write;  // write key at final slot
        logic       finish;     // latch result, update count
        logic       set_ok;
        skt_shift_t shift;
    } skt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       full;
        logic       pos_bad;
        logic       bs_empty;   // lo > hi
        logic       bs_hit;
        logic       ls_end;
        logic       ls_hit;
        logic       sh_end;     // shift walk done
        logic       srt_stop;   // sorted insert found its slot
    } skt_stat_t;

endpackage

@@ design/skt_ram.sv @@
// skt_ram: generic single-port RAM with registered read.
// Depends on nothing.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ design/skt_datapath.sv @@
// skt_datapath: key memory, fill count, search bounds and shift pointer.
// Depends on skt_pkg and skt_ram.
module skt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skt_pkg::skt_cmd_t    cmd,
    output skt_pkg::skt_stat_t   stat,
    input  logic [2:0]           func,
    input  logic signed [31:0]   key,
    input  logic [6:0]           position,
    output logic                 ok,
    output logic [5:0]           found_index,
    output logic [6:0]           fill_count
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // signed bounds: one extra bit so hi can go to -1
    localparam int BW = CW + 1;

    logic [2:0]          func_reg;
    logic [31:0]         key_reg;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       count_reg;
    logic signed [BW-1:0] lo_reg, hi_reg;
    logic [CW-1:0]       ptr_reg;     // walk pointer
    logic [AW-1:0]       slot_reg;
    logic                ok_reg;
    logic                ok_out_reg;
    logic [5:0]          found_reg;
    logic [6:0]          fill_reg;

    logic                we;
    logic [AW-1:0]       addr;
    logic [31:0]         wdata;
    logic [31:0]         rdata;
    logic signed [BW:0]  mid_sum;
    logic [AW-1:0]       mid;
    logic                rd_less;     // stored < key
    logic                key_less_rd; // key < stored
    logic                step_hit;    // search compare matches this cycle
    logic [AW-1:0]       step_slot;

    assign mid_sum = (BW+1)'(lo_reg) + (BW+1)'(hi_reg);
    assign mid = AW'(mid_sum >>> 1);
    assign rd_less = $signed(rdata) < $signed(key_reg);
    assign key_less_rd = $signed(key_reg) < $signed(rdata);
    assign step_hit = (cmd.bs_step || cmd.ls_step) && rdata == key_reg;
    assign step_slot = cmd.bs_step ? mid : ptr_reg[AW-1:0];

    // memory port steering
    always_comb
    begin
        we = 1'b0;
        wdata = rdata;
        addr = ptr_reg[AW-1:0];
        if (cmd.bs_read)
            addr = mid;
        else if (cmd.ls_read)
            addr = ptr_reg[AW-1:0];
        else if (cmd.sh_read)
            addr = (cmd.shift == SH_UP) ? AW'(ptr_reg - 1'b1) : AW'(ptr_reg + 1'b1);
        else if (cmd.sh_write)
            we = 1'b1;
        else if (cmd.ins_write)
        begin
            we = 1'b1;
            wdata = key_reg;
        end
    end

    skt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // command capture and walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg <= key;
            // out-of-range positions clamp to CAPACITY, which always fails
            pos_reg <= (position > 7'(CAPACITY)) ? CW'(CAPACITY) : CW'(position);
            ok_reg <= 1'b0;
            slot_reg <= '0;
        end
        if (cmd.bs_init)
        begin
            lo_reg <= '0;
            hi_reg <= BW'(count_reg) - 1'b1;
        end
        if (cmd.bs_step)
        begin
            if (rdata == key_reg)
            begin
                ok_reg <= 1'b1;
                slot_reg <= mid;
                // delete walks down from the hit slot
                ptr_reg <= CW'(mid);
            end
            else if (rd_less)
                lo_reg <= BW'(mid) + 1'b1;
            else
                hi_reg <= BW'(mid) - 1'b1;
        end
        if (cmd.ls_init)
            ptr_reg <= '0;
        if (cmd.ls_step)
        begin
            if (rdata == key_reg)
            begin
                ok_reg <= 1'b1;
                slot_reg <= ptr_reg[AW-1:0];
            end
            else
                ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.sh_init)
            ptr_reg <= (cmd.shift == SH_UP) ? count_reg : CW'(slot_reg);
        if (cmd.sh_write)
            ptr_reg <= (cmd.shift == SH_UP) ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
        if (cmd.set_ok)
            ok_reg <= 1'b1;
        if (cmd.finish)
        begin
            ok_out_reg <= ok_reg || cmd.set_ok || step_hit;
            if (step_hit)
                found_reg <= 6'(step_slot);
            else
                found_reg <= (ok_reg || cmd.set_ok) ? 6'(slot_reg) : '0;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.finish)
        begin
            if (func_reg == FUNC_CLEAR)
                count_reg <= '0;
            else if (cmd.set_ok && (func_reg == FUNC_INS_POS || func_reg == FUNC_INS_SRT))
                count_reg <= count_reg + 1'b1;
            else if (ok_reg && func_reg == FUNC_DELETE)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (func_reg == FUNC_CLEAR)
                fill_reg <= '0;
            else if (cmd.set_ok && (func_reg == FUNC_INS_POS || func_reg == FUNC_INS_SRT))
                fill_reg <= 7'(count_reg + 1'b1);
            else if (ok_reg && func_reg == FUNC_DELETE)
                fill_reg <= 7'(count_reg - 1'b1);
            else
                fill_reg <= 7'(count_reg);
        end
    end

    assign ok = ok_out_reg;
    assign found_index = found_reg;
    assign fill_count = fill_reg;

    // status back to controller
    always_comb
    begin
        stat.func = func_reg;
        stat.full = count_reg >= CW'(CAPACITY);
        stat.pos_bad = (pos_reg > count_reg);
        stat.bs_empty = lo_reg > hi_reg;
        stat.bs_hit = rdata == key_reg;
        stat.ls_end = ptr_reg >= count_reg;
        stat.ls_hit = rdata == key_reg;
        // delete walks down, inserts walk up
        stat.sh_end = (func_reg == FUNC_DELETE)
            ? (ptr_reg + 1'b1 >= count_reg)
            : (ptr_reg <= ((func_reg == FUNC_INS_POS) ? pos_reg : '0));
        stat.srt_stop = (ptr_reg == '0) || !key_less_rd;
    end
endmodule

@@ design/skt_ctrl.sv @@
// skt_ctrl: command sequencer for the sorted key table.
// Depends on skt_pkg.
module skt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  skt_pkg::skt_stat_t stat,
    output skt_pkg::skt_cmd_t  cmd
);
    import skt_pkg::*;

    skt_state_t state_reg, state_next;
    skt_shift_t shift_reg, shift_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= SH_NONE;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        cmd = '0;
        cmd.shift = shift_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                shift_next = SH_NONE;
                unique case (stat.func)
                    FUNC_CLEAR:
                    begin
                        cmd.set_ok = 1'b1;
                        cmd.finish = 1'b1;
                    end
                    FUNC_INS_POS, FUNC_INS_SRT:
                    begin
                        if (stat.full || (stat.func == FUNC_INS_POS && stat.pos_bad))
                            cmd.finish = 1'b1;
                        else
                        begin
                            shift_next = SH_UP;
                            cmd.shift = SH_UP;
                            cmd.sh_init = 1'b1;
                            state_next = ST_SH_READ;
                        end
                    end
                    FUNC_BSEARCH, FUNC_DELETE:
                    begin
                        cmd.bs_init = 1'b1;
                        state_next = ST_BS_READ;
                    end
                    FUNC_LSEARCH:
                    begin
                        cmd.ls_init = 1'b1;
                        state_next = ST_LS_READ;
                    end
                    default:
                        cmd.finish = 1'b1;
                endcase
            end
            ST_BS_READ:
            begin
                if (stat.bs_empty)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.bs_read = 1'b1;
                    state_next = ST_BS_CMP;
                end
            end
            ST_BS_CMP:
            begin
                cmd.bs_step = 1'b1;
                if (stat.bs_hit)
                begin
                    if (stat.func == FUNC_DELETE)
                    begin
                        shift_next = SH_DOWN;
                        state_next = ST_SH_READ;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else
                    state_next = ST_BS_READ;
            end
            ST_LS_READ:
            begin
                if (stat.ls_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.ls_read = 1'b1;
                    state_next = ST_LS_CMP;
                end
            end
            ST_LS_CMP:
            begin
                cmd.ls_step = 1'b1;
                if (stat.ls_hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_LS_READ;
            end
            ST_SH_READ:
            begin
                // delete: pointer starts at the hit slot
                if (shift_reg == SH_DOWN && stat.sh_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else if (shift_reg == SH_UP && stat.func == FUNC_INS_POS && stat.sh_end)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.set_ok = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else if (shift_reg == SH_UP && stat.func == FUNC_INS_SRT
                         && stat.sh_end)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.set_ok = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sh_read = 1'b1;
                    state_next = ST_SH_WRITE;
                end
            end
            ST_SH_WRITE:
            begin
                if (shift_reg == SH_UP && stat.func == FUNC_INS_SRT && stat.srt_stop)
                begin
                    cmd.ins_write = 1'b1;
                    cmd.set_ok = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sh_write = 1'b1;
                    state_next = ST_SH_READ;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // a result is offered only after a command was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result without pending command");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("accepting while a result waits");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DECODE)
        else $error("load did not start decode");
endmodule

@@ design/sorted_key_table_top.sv @@
// sorted_key_table_top: sorted key table, controller plus datapath.
// Depends on skt_pkg, skt_ctrl, skt_datapath.
//
// Usage: one command per input transaction (func, key, position); one
// result transaction (ok, found_index, fill_count) per command.
// The block holds one command at a time: in_ready is high only while idle,
// and a result stays on the output until out_ready takes it.
// Sequencing: clear and failed inserts finish at decode; binary search and the
// search half of delete do one RAM read then one compare per probe; linear
// search does the same per entry visited; inserts and the shift half of
// delete do one RAM read then one write per moved entry. The single-port key
// RAM sets this sequence.
// Reset empties the table; fill_count is not reset, nor is key memory cleared.
// When the receiver stalls, the result holds and no new command is taken.
module sorted_key_table_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] key,
    input  logic [6:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic [5:0]         found_index,
    output logic [6:0]         fill_count
);
    import skt_pkg::*;

    skt_cmd_t  cmd;
    skt_stat_t stat;

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    skt_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .func        (func),
        .key         (key),
        .position    (position),
        .ok          (ok),
        .found_index (found_index),
        .fill_count  (fill_count)
    );
endmodule
